[rtl/infix_integer_expression_evaluator_macros.svh]
// Assertion helpers for the evaluator RTL.
`ifndef INFIX_INTEGER_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_INTEGER_EXPRESSION_EVALUATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define IIEE_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define IIEE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/iiee_pkg.sv]
`default_nettype none

package iiee_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH     = 4;
    localparam int OUT_VALUE_W     = 32;
    localparam int STATUS_W        = 2;

    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 2'd2;

    // Classified character
    typedef enum logic [2:0] {
        OP_DIGIT,
        OP_NOP,
        OP_BAD,
        OP_MUL,
        OP_DIV,
        OP_ADD,
        OP_SUB
    } op_t;

    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_MUL,
        PEND_DIV
    } pend_t;

    typedef enum logic [2:0] {
        ST_FETCH,
        ST_FACTOR,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_POST
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] digit;
        logic       last;
    } q_entry_t;

endpackage

`default_nettype wire

[rtl/infix_integer_expression_evaluator.sv]
// Channel   | Dir | Signals                         | Carries
// ----------+-----+---------------------------------+------------------------------------
// s_ (in)   | in  | s_tvalid s_tready s_tdata s_tlast | one ASCII character, tlast = end
// m_ (out)  | out | m_tvalid m_tready m_tdata        | value and status of one expression
//
// A digit is added into the current number as it is fetched; a space that does not end
// the expression is dropped by the classifier. An operator passes through the factor and
// post steps, with the multiply steps between them after a pending multiply, or the divide
// and fix steps after a pending nonzero divide; closing the expression repeats that.
// Reset (rst_n low, asynchronous) empties the 4-entry queue and clears all sums.
// The queue lets the classifier run ahead; a held result stalls only the next close.
`default_nettype none

`include "infix_integer_expression_evaluator_macros.svh"

module infix_integer_expression_evaluator #(
    parameter int VALUE_WIDTH = iiee_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // [31:0] value, [33:32] status, [39:34] zero
);

    iiee_pkg::q_entry_t  f_ent;
    logic                f_valid;
    logic                f_ready;
    iiee_pkg::q_entry_t  q_ent;
    logic                q_valid;
    logic                q_ready;
    logic [iiee_pkg::OUT_VALUE_W-1:0] res_value;
    logic [iiee_pkg::STATUS_W-1:0]    res_status;
    logic                res_err;

    // Classify characters and hold one for the queue
    iiee_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .ent       (f_ent),
        .ent_valid (f_valid),
        .ent_ready (f_ready)
    );

    // Decouple the classifier from the engine
    iiee_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ent    (f_ent),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .out_ent   (q_ent),
        .out_valid (q_valid),
        .out_ready (q_ready)
    );

    // Evaluate and register the result
    iiee_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_ent      (q_ent),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (res_value),
        .out_status (res_status)
    );

    // Pack the result transfer, zero-fill to whole bytes
    assign m_tdata = {6'd0, res_status, res_value};

    assign res_err = (res_status != iiee_pkg::STATUS_OK);

    `IIEE_ASSERT_IMPLY(a_err_value_zero, m_tvalid && res_err, res_value == '0, "error value")
    `IIEE_ASSERT_IMPLY(a_status_code, m_tvalid, res_status != 2'd3, "unknown status code")
    `IIEE_ASSERT_IMPLY(a_stall_cause, !s_tready, f_valid && !f_ready, "stall without cause")
    `IIEE_ASSERT_NEXT(a_fill_hold, f_valid && !f_ready, f_valid, "held character dropped")

endmodule

`default_nettype wire

[rtl/iiee_front.sv]
`default_nettype none

module iiee_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,    // [7:0] char_code
    input  wire logic               s_tlast,
    output iiee_pkg::q_entry_t      ent,
    output logic                    ent_valid,
    input  wire logic               ent_ready
);

    logic                hold_valid_reg;
    logic                hold_valid_next;
    iiee_pkg::q_entry_t  hold_reg;
    iiee_pkg::q_entry_t  hold_next;
    iiee_pkg::q_entry_t  cls;
    logic                keep;
    logic                accept;

    // Classify the incoming character
    always_comb
    begin
        cls.digit = 4'(s_tdata - iiee_pkg::CH_ZERO);
        cls.last  = s_tlast;
        priority if (s_tdata >= iiee_pkg::CH_ZERO && s_tdata <= iiee_pkg::CH_NINE)
        begin
            cls.op = iiee_pkg::OP_DIGIT;
        end
        else if (s_tdata == iiee_pkg::CH_SPACE)
        begin
            cls.op = iiee_pkg::OP_NOP;
        end
        else if (s_tdata == iiee_pkg::CH_MUL)
        begin
            cls.op = iiee_pkg::OP_MUL;
        end
        else if (s_tdata == iiee_pkg::CH_DIV)
        begin
            cls.op = iiee_pkg::OP_DIV;
        end
        else if (s_tdata == iiee_pkg::CH_ADD)
        begin
            cls.op = iiee_pkg::OP_ADD;
        end
        else if (s_tdata == iiee_pkg::CH_SUB)
        begin
            cls.op = iiee_pkg::OP_SUB;
        end
        else
        begin
            cls.op = iiee_pkg::OP_BAD;
        end
    end

    // Drop spaces unless they close the expression
    assign keep     = !(cls.op == iiee_pkg::OP_NOP && !s_tlast);
    assign s_tready = !hold_valid_reg || ent_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (ent_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept && keep)
        begin
            hold_valid_next = 1'b1;
            hold_next       = cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign ent       = hold_reg;
    assign ent_valid = hold_valid_reg;

endmodule

`default_nettype wire

[rtl/iiee_queue.sv]
`default_nettype none

module iiee_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire iiee_pkg::q_entry_t in_ent,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output iiee_pkg::q_entry_t      out_ent,
    output logic                    out_valid,
    input  wire logic               out_ready
);

    localparam int DEPTH = iiee_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    iiee_pkg::q_entry_t  mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                push;
    logic                pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_ent   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_ent;
        end
    end

endmodule

`default_nettype wire

[rtl/iiee_back.sv]
`default_nettype none

module iiee_back #(
    parameter int VALUE_WIDTH = iiee_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire iiee_pkg::q_entry_t             q_ent,
    input  wire logic                           q_valid,
    output logic                                q_ready,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [iiee_pkg::OUT_VALUE_W-1:0]    out_value,
    output logic [iiee_pkg::STATUS_W-1:0]       out_status
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(W + 1);

    iiee_pkg::state_t  state_reg, state_next;
    logic [W-1:0]      sum_reg, sum_next;
    logic [W-1:0]      term_reg, term_next;
    logic [W-1:0]      num_reg, num_next;
    logic              neg_reg, neg_next;
    iiee_pkg::pend_t   pend_reg, pend_next;
    logic              bad_reg, bad_next;
    logic              dz_reg, dz_next;
    logic              closing_reg, closing_next;
    iiee_pkg::op_t     cur_op_reg, cur_op_next;
    logic              cur_last_reg, cur_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [iiee_pkg::OUT_VALUE_W-1:0] out_value_reg, out_value_next;
    logic [iiee_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;

    // Shared shift-add / restoring-divide unit
    logic [W-1:0]      a_reg, a_next;
    logic [W-1:0]      b_reg, b_next;
    logic [W-1:0]      p_reg, p_next;
    logic              qneg_reg, qneg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              is_oper;
    logic              pop;
    logic              out_free;
    logic              step_last;
    logic [W-1:0]      sum_fin;
    logic [W-1:0]      mul_acc;
    logic [W:0]        rem_sh;
    logic [W:0]        rem_diff;
    logic              rem_ge;
    logic [iiee_pkg::STATUS_W-1:0] status_fin;

    assign q_ready   = (state_reg == iiee_pkg::ST_FETCH);
    assign pop       = q_ready && q_valid;
    assign is_oper   = (q_ent.op == iiee_pkg::OP_MUL) || (q_ent.op == iiee_pkg::OP_DIV)
                    || (q_ent.op == iiee_pkg::OP_ADD) || (q_ent.op == iiee_pkg::OP_SUB);
    assign out_free  = !out_valid_reg || out_ready;
    assign step_last = (cnt_reg == CNT_W'(W - 1));
    assign sum_fin   = neg_reg ? (sum_reg - term_reg) : (sum_reg + term_reg);
    assign mul_acc   = p_reg + (b_reg[0] ? a_reg : '0);
    assign rem_sh    = {p_reg, a_reg[W-1]};
    assign rem_diff  = rem_sh - {1'b0, b_reg};
    assign rem_ge    = !rem_diff[W];

    always_comb
    begin
        priority if (bad_reg)
        begin
            status_fin = iiee_pkg::STATUS_BAD_CHAR;
        end
        else if (dz_reg)
        begin
            status_fin = iiee_pkg::STATUS_DIV_ZERO;
        end
        else
        begin
            status_fin = iiee_pkg::STATUS_OK;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            iiee_pkg::ST_FETCH:
            begin
                if (q_valid && (is_oper || q_ent.last))
                begin
                    state_next = iiee_pkg::ST_FACTOR;
                end
            end
            iiee_pkg::ST_FACTOR:
            begin
                unique case (pend_reg)
                    iiee_pkg::PEND_MUL: state_next = iiee_pkg::ST_MUL;
                    iiee_pkg::PEND_DIV:
                        state_next = (num_reg == '0) ? iiee_pkg::ST_POST : iiee_pkg::ST_DIV;
                    default:            state_next = iiee_pkg::ST_POST;
                endcase
            end
            iiee_pkg::ST_MUL:
            begin
                if (step_last)
                begin
                    state_next = iiee_pkg::ST_POST;
                end
            end
            iiee_pkg::ST_DIV:
            begin
                if (step_last)
                begin
                    state_next = iiee_pkg::ST_FIX;
                end
            end
            iiee_pkg::ST_FIX:
            begin
                state_next = iiee_pkg::ST_POST;
            end
            iiee_pkg::ST_POST:
            begin
                if (!closing_reg)
                begin
                    state_next = cur_last_reg ? iiee_pkg::ST_FACTOR : iiee_pkg::ST_FETCH;
                end
                else if (out_free)
                begin
                    state_next = iiee_pkg::ST_FETCH;
                end
            end
            default:
            begin
                state_next = iiee_pkg::ST_FETCH;
            end
        endcase
    end

    // Datapath and result
    always_comb
    begin
        sum_next        = sum_reg;
        term_next       = term_reg;
        num_next        = num_reg;
        neg_next        = neg_reg;
        pend_next       = pend_reg;
        bad_next        = bad_reg;
        dz_next         = dz_reg;
        closing_next    = closing_reg;
        cur_op_next     = cur_op_reg;
        cur_last_next   = cur_last_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        p_next          = p_reg;
        qneg_next       = qneg_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            iiee_pkg::ST_FETCH:
            begin
                if (pop)
                begin
                    cur_op_next   = q_ent.op;
                    cur_last_next = q_ent.last;
                    closing_next  = !is_oper;
                    if (q_ent.op == iiee_pkg::OP_DIGIT)
                    begin
                        num_next = (num_reg << 3) + (num_reg << 1) + W'(q_ent.digit);
                    end
                    if (q_ent.op == iiee_pkg::OP_BAD)
                    begin
                        bad_next = 1'b1;
                    end
                end
            end
            iiee_pkg::ST_FACTOR:
            begin
                num_next = '0;
                cnt_next = '0;
                p_next   = '0;
                unique case (pend_reg)
                    iiee_pkg::PEND_MUL:
                    begin
                        a_next = term_reg;
                        b_next = num_reg;
                    end
                    iiee_pkg::PEND_DIV:
                    begin
                        if (num_reg == '0)
                        begin
                            dz_next   = 1'b1;
                            term_next = '0;
                        end
                        else
                        begin
                            a_next    = term_reg[W-1] ? -term_reg : term_reg;
                            b_next    = num_reg[W-1] ? -num_reg : num_reg;
                            qneg_next = term_reg[W-1] ^ num_reg[W-1];
                        end
                    end
                    default:
                    begin
                        term_next = num_reg;
                    end
                endcase
            end
            iiee_pkg::ST_MUL:
            begin
                p_next   = mul_acc;
                a_next   = a_reg << 1;
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (step_last)
                begin
                    term_next = mul_acc;
                end
            end
            iiee_pkg::ST_DIV:
            begin
                p_next   = rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
                a_next   = {a_reg[W-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            iiee_pkg::ST_FIX:
            begin
                term_next = qneg_reg ? -a_reg : a_reg;
            end
            iiee_pkg::ST_POST:
            begin
                if (!closing_reg)
                begin
                    unique case (cur_op_reg)
                        iiee_pkg::OP_MUL: pend_next = iiee_pkg::PEND_MUL;
                        iiee_pkg::OP_DIV: pend_next = iiee_pkg::PEND_DIV;
                        iiee_pkg::OP_ADD, iiee_pkg::OP_SUB:
                        begin
                            sum_next  = sum_fin;
                            term_next = '0;
                            pend_next = iiee_pkg::PEND_NONE;
                            neg_next  = (cur_op_reg == iiee_pkg::OP_SUB);
                        end
                        default:
                        begin
                        end
                    endcase
                    if (cur_last_reg)
                    begin
                        closing_next = 1'b1;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_fin;
                    out_value_next  = (status_fin == iiee_pkg::STATUS_OK)
                                    ? iiee_pkg::OUT_VALUE_W'($signed(sum_fin)) : '0;
                    sum_next        = '0;
                    term_next       = '0;
                    num_next        = '0;
                    neg_next        = 1'b0;
                    pend_next       = iiee_pkg::PEND_NONE;
                    bad_next        = 1'b0;
                    dz_next         = 1'b0;
                    closing_next    = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iiee_pkg::ST_FETCH;
            sum_reg       <= '0;
            term_reg      <= '0;
            num_reg       <= '0;
            neg_reg       <= 1'b0;
            pend_reg      <= iiee_pkg::PEND_NONE;
            bad_reg       <= 1'b0;
            dz_reg        <= 1'b0;
            closing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            term_reg      <= term_next;
            num_reg       <= num_next;
            neg_reg       <= neg_next;
            pend_reg      <= pend_next;
            bad_reg       <= bad_next;
            dz_reg        <= dz_next;
            closing_reg   <= closing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_op_reg     <= cur_op_next;
        cur_last_reg   <= cur_last_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        p_reg          <= p_next;
        qneg_reg       <= qneg_next;
        cnt_reg        <= cnt_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire
